>>> design/bfr_pkg.sv
// Package for the byte ring FIFO: request and status codes, the default
// ring depth and the result record passed between the control and output stages.
// No dependencies.
package bfr_pkg;

  localparam int unsigned BfrDepthDef = 256;

  localparam int unsigned OccW = 9;

  localparam logic [1:0] ReqPush  = 2'd0;
  localparam logic [1:0] ReqPop   = 2'd1;
  localparam logic [1:0] ReqFlush = 2'd2;
  localparam logic [1:0] ReqKeep  = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StOverrun  = 2'd1;
  localparam logic [1:0] StUnderrun = 2'd2;

  // Everything about one result except the byte itself, which arrives from
  // the store's read register in the cycle after the request is taken.
  typedef struct packed {
    logic            read_valid;
    logic            known;
    logic [1:0]      status;
    logic [OccW-1:0] occupancy;
    logic            is_full;
  } bfr_res_t;

endpackage

>>> design/bfr_store.sv
// Byte store of the ring FIFO: one write port and one registered read port.
// Depends on bfr_pkg for the default depth.
module bfr_store
  import bfr_pkg::*;
#(
  parameter int unsigned DEPTH = BfrDepthDef
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [7:0]               wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [7:0]               rd_data_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> design/bfr_ctrl.sv
// Pointer and count control of the ring FIFO: decodes each request, updates
// the pointers, drives the store ports and forms the result record.
// Depends on bfr_pkg.
module bfr_ctrl
  import bfr_pkg::*;
#(
  parameter int unsigned DEPTH = BfrDepthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     acc_i,
  input  logic [1:0]               req_type_i,
  input  logic [7:0]               data_in_i,
  output logic                     wr_en_o,
  output logic [$clog2(DEPTH)-1:0] wr_addr_o,
  output logic [7:0]               wr_data_o,
  output logic [$clog2(DEPTH)-1:0] rd_addr_o,
  output bfr_res_t                 res_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wrap_q, wrap_d;
  logic [PtrW-1:0] wptr_next, rptr_next, wptr_prev;
  logic            wr_en;
  logic            rvalid;
  logic [1:0]      status;

  assign wptr_next = (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
  assign rptr_next = (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
  assign wptr_prev = (wptr_q == '0) ? PtrLast : wptr_q - PtrW'(1);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    wrap_d = wrap_q;
    wr_en  = 1'b0;
    rvalid = 1'b0;
    status = StOk;
    unique case (req_type_i)
      ReqPush: begin
        if (cnt_q == CntFull) begin
          status = StOverrun;
        end else begin
          wr_en  = 1'b1;
          wptr_d = wptr_next;
          cnt_d  = cnt_q + CntW'(1);
          if (wptr_q == PtrLast) begin
            wrap_d = 1'b1;
          end
        end
      end
      ReqPop: begin
        if (cnt_q == '0) begin
          status = StUnderrun;
        end else begin
          rvalid = 1'b1;
          rptr_d = rptr_next;
          cnt_d  = cnt_q - CntW'(1);
        end
      end
      ReqFlush: begin
        rptr_d = wptr_q;
        cnt_d  = '0;
      end
      default: begin
        rptr_d = wptr_prev;
        cnt_d  = CntW'(1);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
      wrap_q <= 1'b0;
    end else if (acc_i) begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
      wrap_q <= wrap_d;
    end
  end

  assign wr_en_o   = acc_i && wr_en;
  assign wr_addr_o = wptr_q;
  assign wr_data_o = data_in_i;
  assign rd_addr_o = rptr_q;

  // Writes fill the ring in order from slot zero, so until the write pointer
  // has wrapped once only the slots below it have ever been written; any
  // other slot holds no defined value, since the store has no reset.
  always_comb begin
    res_o.read_valid = rvalid;
    res_o.known      = wrap_q || (rptr_q < wptr_q);
    res_o.status     = status;
    res_o.occupancy  = OccW'(cnt_d);
    res_o.is_full    = (cnt_d == CntFull);
  end

endmodule

>>> design/bfr_outq.sv
// Result path of the ring FIFO: a stage that meets the store's read register
// and an output register, so a new request is taken while a result waits.
// Depends on bfr_pkg.
module bfr_outq
  import bfr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  bfr_res_t        res_i,
  input  logic [7:0]      rd_data_i,
  input  logic            out_stall_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output logic [7:0]      read_data_o,
  output logic            read_valid_o,
  output logic [1:0]      status_o,
  output logic [OccW-1:0] occupancy_o,
  output logic            is_full_o
);

  logic     a_valid_q, a_valid_d;
  bfr_res_t a_res_q;
  logic     o_valid_q, o_valid_d;
  bfr_res_t o_res_q;
  logic [7:0] o_data_q;
  logic     move;

  assign move       = a_valid_q && (!o_valid_q || !out_stall_i);
  assign in_stall_o = a_valid_q && !move;
  assign a_valid_d  = acc_i || (a_valid_q && !move);
  assign o_valid_d  = move || (o_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      a_res_q <= res_i;
    end
  end

  // The store byte is only meaningful for a successful pop of a slot that
  // has been written since reset.
  always_ff @(posedge clk_i) begin
    if (move) begin
      o_res_q  <= a_res_q;
      o_data_q <= (a_res_q.read_valid && a_res_q.known) ? rd_data_i : 8'd0;
    end
  end

  assign out_valid_o  = o_valid_q;
  assign read_data_o  = o_data_q;
  assign read_valid_o = o_res_q.read_valid;
  assign status_o     = o_res_q.status;
  assign occupancy_o  = o_res_q.occupancy;
  assign is_full_o    = o_res_q.is_full;

endmodule

>>> design/byte_ring_fifo_unit.sv
// Byte ring FIFO top level: control, store and result path.
// Depends on bfr_pkg, bfr_ctrl, bfr_store and bfr_outq.
//
// A byte queue of DEPTH entries that takes one request (push, pop, flush or
// keep-last) per clock cycle while in_stall_o is low and gives one result per
// request, in request order. A taken request's byte goes into the store's
// registered read port and its record into the result stage, then both move
// on to the output register; pointer and count updates finish in the cycle of
// the request, so back-to-back requests see each other at once.
// A result sitting in the output register does not hold off the next request;
// the input stalls only when both the result stage and the output register
// are full and the output is stalled. No clearing pass follows reset: slots
// not yet written since reset are tracked by the write pointer and read as zero.
module byte_ring_fifo_unit
  import bfr_pkg::*;
#(
  parameter int unsigned DEPTH = BfrDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      req_type_i,
  input  logic [7:0]      data_in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      read_data_o,
  output logic            read_valid_o,
  output logic [1:0]      status_o,
  output logic [OccW-1:0] occupancy_o,
  output logic            is_full_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);

  logic            acc;
  logic            wr_en;
  logic [PtrW-1:0] wr_addr;
  logic [7:0]      wr_data;
  logic [PtrW-1:0] rd_addr;
  logic [7:0]      rd_data;
  bfr_res_t        res;

  assign acc = in_valid_i && !in_stall_o;

  bfr_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .req_type_i(req_type_i),
    .data_in_i (data_in_i),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_addr_o (rd_addr),
    .res_o     (res)
  );

  bfr_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (acc),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  bfr_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .res_i       (res),
    .rd_data_i   (rd_data),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .read_data_o (read_data_o),
    .read_valid_o(read_valid_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o),
    .is_full_o   (is_full_o)
  );

`ifndef SYNTHESIS
  a_stall_only_when_backed_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output register could drain");

  a_pop_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && read_valid_o) |-> (status_o == StOk))
    else $error("returned byte carries a failure status");

  a_full_matches_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_full_o) |-> (occupancy_o == OccW'(DEPTH)))
    else $error("full flag disagrees with occupancy");

  a_push_result_not_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (req_type_i == ReqPush)) |-> (res.status != StUnderrun))
    else $error("push request reported underrun");
`endif

endmodule
